### hdl/adsr_pkg.sv
// Shared types and constants for the ADSR envelope generator.
`timescale 1ns / 1ps

package adsr_pkg;

    localparam int DATA_W     = 12;              // time registers, targets, steps
    localparam int LEVEL_W    = 13;              // envelope levels
    localparam int VEL_W      = 7;
    localparam int ANGLE_W    = 8;
    localparam int SCALE_W    = 6;
    localparam int GAIN_W     = 8;
    localparam int ENV_W      = 16;
    localparam int AGE_W      = 32;
    localparam int PROD_W     = LEVEL_W + GAIN_W;
    localparam int CFG_ADDR_W = 3;

    // divider: quotient bits retired per cycle and cycles per division
    localparam int DIV_BITS   = 2;
    localparam int DIV_CYCLES = DATA_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    localparam logic [DATA_W-1:0]  FULL_SCALE  = 12'hfff;
    localparam logic [4:0]         PEAK_FILL   = 5'h1f;
    localparam logic [ANGLE_W-1:0] CLOSE_ANGLE = 8'd224;
    localparam logic [SCALE_W-1:0] SCALE_MAX   = 6'd32;
    localparam logic [AGE_W-1:0]   AGE_MAX     = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ATTACK_TIME   = 3'd0,
        REG_DECAY_TIME    = 3'd1,
        REG_RELEASE_TIME  = 3'd2,
        REG_SUSTAIN_SCALE = 3'd3,
        REG_OUTPUT_GAIN   = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_ON     = 2'd1,
        MODE_GO_OFF = 2'd2
    } voice_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4,
        ST_CLOSE   = 3'd5
    } env_stage_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_DIV_A = 6'b000100,
        S_DIV_D = 6'b001000,
        S_DIV_R = 6'b010000,
        S_FIN   = 6'b100000
    } seq_state_t;

endpackage

### hdl/adsr_envelope_generator_core.sv
// Top level of the single-voice linear ADSR envelope generator.
`timescale 1ns / 1ps

// Usage:
//  Input stream (s_axis_*): one transfer per command. tuser carries the op
//  (tick, note on, note off; the fourth code is ignored), tdata carries
//  velocity and phase angle. Output stream (m_axis_*): exactly one result
//  transfer per input transfer, in order.
//  Config port: cfg_we/cfg_addr/cfg_wdata write the five registers; write
//  them only while no command is in flight.
//  Commands are handled one at a time under a small sequencer: a tick, note
//  off or ignored op goes through its execute state and then the final
//  state, where it loads the result register; a note on also runs the three
//  serial step divisions on the one shared divider (2 quotient bits/cycle)
//  between those states. The next command is taken only once the result is
//  loaded; s_axis_tready is high only while the sequencer is idle.
//  The result sits in an output register: while the receiver stalls, the
//  next command is still accepted and processed, and the sequencer waits in
//  its final state until the output register frees up.
//  Reset (async, rst_n low): registers return to 64/64/64/16/255, the voice
//  is off, levels and steps take their power-up values, no result pending.

module adsr_envelope_generator_core
    import adsr_pkg::*;
#(
    parameter int GAIN_SHIFT = 8          // 0..16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // velocity[6:0], phase_angle[14:7], 0
    input  logic [1:0]            s_axis_tuser,   // op[1:0]
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [55:0]           m_axis_tdata,   // envelope[15:0], stage[18:16],
                                                  // active[19], age[51:20], 0
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wdata
);

    // configuration registers
    logic [DATA_W-1:0]  attack_time_reg, decay_time_reg, release_time_reg;
    logic [SCALE_W-1:0] sustain_scale_reg;
    logic [GAIN_W-1:0]  output_gain_reg;

    // sequencer and latched command
    seq_state_t         state_reg, state_next;
    op_t                op_reg;
    logic [VEL_W-1:0]   vel_reg;
    logic [ANGLE_W-1:0] angle_reg;

    // voice state
    voice_mode_t        mode_reg;
    env_stage_t         stage_reg;
    logic [LEVEL_W-1:0] attack_level_reg, decay_level_reg, hold_level_reg, release_level_reg;
    logic [DATA_W-1:0]  peak_reg, sustain_reg;
    logic [DATA_W-1:0]  attack_step_reg, decay_step_reg, release_step_reg;
    logic [AGE_W-1:0]   age_reg;
    logic [LEVEL_W-1:0] level_reg;     // level reported by the current command

    // output register
    logic               out_valid_reg;
    logic [ENV_W-1:0]   out_env_reg;
    logic [2:0]         out_stage_reg;
    logic               out_active_reg;
    logic [AGE_W-1:0]   out_age_reg;

    // shared divider
    logic              div_start, div_busy, div_done;
    logic [DATA_W-1:0] div_dividend, div_divisor, div_quotient, div_step;

    logic              in_xfer, out_load;
    logic [DATA_W-1:0] peak_new;
    logic [LEVEL_W:0]  attack_sum;
    logic [LEVEL_W-1:0] decay_sub, release_sub;
    logic [PROD_W-1:0] env_prod, env_shifted;
    logic [LEVEL_W-1:0] sustain_prod;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || m_axis_tready);

    assign peak_new     = {vel_reg, PEAK_FILL};
    assign sustain_prod = LEVEL_W'(sustain_scale_reg) * LEVEL_W'(vel_reg);

    // tick arithmetic
    assign attack_sum  = {1'b0, attack_level_reg} + {2'b00, attack_step_reg};
    assign decay_sub   = (decay_level_reg > {1'b0, decay_step_reg})
                       ? decay_level_reg - {1'b0, decay_step_reg} : '0;
    assign release_sub = (release_level_reg > {1'b0, release_step_reg})
                       ? release_level_reg - {1'b0, release_step_reg} : '0;

    assign env_prod    = PROD_W'(level_reg) * PROD_W'(output_gain_reg);
    assign env_shifted = env_prod >> GAIN_SHIFT;

    // divider operand select; zero time divides as one
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = peak_new;
        div_divisor  = attack_time_reg;
        case (state_reg)
            S_EXEC:
            begin
                div_start = (op_reg == OP_NOTE_ON);
            end
            S_DIV_A:
            begin
                div_start    = div_done;
                div_dividend = sustain_reg;
                div_divisor  = decay_time_reg;
            end
            S_DIV_D:
            begin
                div_start    = div_done;
                div_dividend = FULL_SCALE;
                div_divisor  = release_time_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
        if (div_divisor == '0)
            div_divisor = DATA_W'(1);
    end

    assign div_step = (div_quotient == '0) ? DATA_W'(1) : div_quotient;

    adsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_xfer) state_next = S_EXEC;
            S_EXEC:  state_next = (op_reg == OP_NOTE_ON) ? S_DIV_A : S_FIN;
            S_DIV_A: if (div_done) state_next = S_DIV_D;
            S_DIV_D: if (div_done) state_next = S_DIV_R;
            S_DIV_R: if (div_done) state_next = S_FIN;
            S_FIN:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // latched command fields
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= op_t'(s_axis_tuser);
            vel_reg   <= s_axis_tdata[6:0];
            angle_reg <= s_axis_tdata[14:7];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_time_reg   <= DATA_W'(64);
            decay_time_reg    <= DATA_W'(64);
            release_time_reg  <= DATA_W'(64);
            sustain_scale_reg <= SCALE_W'(16);
            output_gain_reg   <= GAIN_W'(255);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ATTACK_TIME:   attack_time_reg  <= cfg_wdata;
                REG_DECAY_TIME:    decay_time_reg   <= cfg_wdata;
                REG_RELEASE_TIME:  release_time_reg <= cfg_wdata;
                REG_SUSTAIN_SCALE: sustain_scale_reg <=
                    (cfg_wdata[SCALE_W-1:0] > SCALE_MAX) ? SCALE_MAX : cfg_wdata[SCALE_W-1:0];
                REG_OUTPUT_GAIN:   output_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // voice state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_OFF;
            stage_reg         <= ST_ATTACK;
            attack_level_reg  <= '0;
            decay_level_reg   <= LEVEL_W'(FULL_SCALE);
            hold_level_reg    <= LEVEL_W'(FULL_SCALE);
            release_level_reg <= LEVEL_W'(FULL_SCALE);
            peak_reg          <= '0;
            sustain_reg       <= '0;
            attack_step_reg   <= DATA_W'(1);
            decay_step_reg    <= DATA_W'(1);
            release_step_reg  <= DATA_W'(1);
            age_reg           <= '0;
            level_reg         <= '0;
        end
        else
        begin
            case (state_reg)
                S_EXEC:
                begin
                    level_reg <= '0;
                    case (op_reg)
                        OP_TICK:
                        begin
                            if (mode_reg != MODE_OFF)
                            begin
                                if (age_reg != AGE_MAX)
                                    age_reg <= age_reg + 1'b1;
                                case (stage_reg)
                                    ST_ATTACK:
                                    begin
                                        attack_level_reg <= attack_sum[LEVEL_W-1:0];
                                        level_reg        <= attack_sum[LEVEL_W-1:0];
                                        if (attack_sum[LEVEL_W-1:0] >= {1'b0, peak_reg})
                                        begin
                                            decay_level_reg <= attack_sum[LEVEL_W-1:0];
                                            stage_reg       <= ST_DECAY;
                                        end
                                    end
                                    ST_DECAY:
                                    begin
                                        decay_level_reg <= decay_sub;
                                        level_reg       <= decay_sub;
                                        if (decay_sub <= {1'b0, sustain_reg})
                                        begin
                                            hold_level_reg <= decay_sub;
                                            stage_reg      <= ST_SUSTAIN;
                                        end
                                    end
                                    ST_SUSTAIN:
                                    begin
                                        level_reg <= hold_level_reg;
                                        if (mode_reg == MODE_GO_OFF)
                                        begin
                                            stage_reg         <= ST_RELEASE;
                                            release_level_reg <= hold_level_reg;
                                        end
                                    end
                                    ST_RELEASE:
                                    begin
                                        release_level_reg <= release_sub;
                                        level_reg         <= release_sub;
                                        if (release_sub <= {1'b0, release_step_reg})
                                            stage_reg <= ST_CLOSE;
                                    end
                                    default:
                                    begin
                                        // close: wait for the phase angle to pass CLOSE_ANGLE near the top
                                        if (angle_reg > CLOSE_ANGLE)
                                        begin
                                            mode_reg <= MODE_OFF;
                                            age_reg  <= '0;
                                        end
                                    end
                                endcase
                            end
                        end
                        OP_NOTE_ON:
                        begin
                            attack_level_reg  <= '0;
                            decay_level_reg   <= LEVEL_W'(FULL_SCALE);
                            hold_level_reg    <= LEVEL_W'(FULL_SCALE);
                            release_level_reg <= LEVEL_W'(FULL_SCALE);
                            peak_reg          <= peak_new;
                            sustain_reg       <= sustain_prod[DATA_W-1:0];
                            stage_reg         <= ST_ATTACK;
                            mode_reg          <= MODE_ON;
                        end
                        OP_NOTE_OFF:
                        begin
                            if (mode_reg != MODE_OFF)
                                mode_reg <= MODE_GO_OFF;
                        end
                        default: ;
                    endcase
                end
                S_DIV_A: if (div_done) attack_step_reg  <= div_step;
                S_DIV_D: if (div_done) decay_step_reg   <= div_step;
                S_DIV_R: if (div_done) release_step_reg <= div_step;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_env_reg    <= env_shifted[ENV_W-1:0];
            out_stage_reg  <= (mode_reg == MODE_OFF) ? ST_IDLE : stage_reg;
            out_active_reg <= (mode_reg != MODE_OFF);
            out_age_reg    <= age_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_age_reg, out_active_reg, out_stage_reg, out_env_reg};

    // checks
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_steps_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (attack_step_reg != '0) && (decay_step_reg != '0) && (release_step_reg != '0))
        else $error("envelope step reached zero");

    a_scale_capped: assert property (@(posedge clk) disable iff (!rst_n)
        sustain_scale_reg <= SCALE_MAX)
        else $error("sustain scale above cap");

    a_active_stage: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_active_reg == (out_stage_reg != ST_IDLE)))
        else $error("active flag disagrees with stage");

    a_div_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_A || state_reg == S_DIV_D || state_reg == S_DIV_R))
        else $error("divider result with no consumer");

endmodule

### hdl/adsr_div.sv
// Shared iterative unsigned divider, radix 2 restoring, two quotient bits per cycle.
`timescale 1ns / 1ps

module adsr_div
    import adsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,    // must be nonzero
    output logic              busy,
    output logic              done,       // one-cycle pulse, quotient valid
    output logic [DATA_W-1:0] quotient
);

    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_comb
    begin
        logic [DATA_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial    = {rem_next, quo_next[DATA_W-1]};
            quo_next = {quo_next[DATA_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial       = trial - {1'b0, div_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_CYCLES);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
